>>> hw/rtl/vba_pkg.sv
// Package for the vector bearing block: widths, bearing and octant constants,
// and the item types passed between the front end, queue, divider and back end.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package vba_pkg;

    localparam int IN_W       = 16;
    localparam int BRG_W      = 16;
    localparam int FRAC_BITS  = 14;
    // Quotient (min << 14) / max lies in 0..16384, so 15 bits.
    localparam int Q_W        = FRAC_BITS + 1;
    // Partial remainder stays below the divisor, at most 32768, before a shift.
    localparam int REM_W      = IN_W + 1;
    localparam int DIV_STAGES = Q_W;
    // Correction term is at most about 2000, well inside 13 bits.
    localparam int CORR_W     = 13;
    localparam int Q_DEPTH    = 2;

    localparam logic [BRG_W-1:0] BRG_NORTH = 16'h0000;
    localparam logic [BRG_W-1:0] BRG_EAST  = 16'h4000;
    localparam logic [BRG_W-1:0] BRG_SOUTH = 16'h8000;
    localparam logic [BRG_W-1:0] BRG_WEST  = 16'hC000;

    localparam logic [Q_W-1:0]    OCT_MID   = 15'h1333;
    localparam logic [CORR_W:0]   OCT_BASE  = 14'h2800;
    localparam logic [11:0]       OCT_CURVE = 12'hB00;

    // Everything the back end needs to fold the octant angle into a bearing.
    typedef struct packed {
        logic             axis;
        logic [BRG_W-1:0] axis_brg;
        logic             x_pos;
        logic             y_pos;
        logic             swapped;
    } t_tag;

    typedef struct packed {
        t_tag            tag;
        logic [IN_W-1:0] lo;
        logic [IN_W-1:0] hi;
    } t_item;

endpackage

`default_nettype wire

>>> hw/rtl/vba_front.sv
// Front end of the bearing block: takes the command beat, sorts out the axis
// cases and the octant, and forms the magnitudes for the divider.
// Depends on vba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vba_front
    import vba_pkg::*;
(
    input  wire logic                   i_start,
    input  wire logic                   i_full,
    input  wire logic signed [IN_W-1:0] i_delta_x,
    input  wire logic signed [IN_W-1:0] i_delta_y,
    output logic                        o_busy,
    output logic                        o_push,
    output t_item                       o_item
);

    logic [IN_W-1:0] s_x;
    logic [IN_W-1:0] s_y;
    logic [IN_W-1:0] s_ax;
    logic [IN_W-1:0] s_ay;
    logic            s_x_zero;
    logic            s_y_zero;
    logic            s_x_pos;
    logic            s_y_pos;
    logic            s_swapped;

    assign s_x = i_delta_x;
    assign s_y = i_delta_y;

    // A component of -32768 comes out as 32768, which still fits unsigned.
    assign s_ax = s_x[IN_W-1] ? (~s_x + IN_W'(1)) : s_x;
    assign s_ay = s_y[IN_W-1] ? (~s_y + IN_W'(1)) : s_y;

    assign s_x_zero  = (s_x == '0);
    assign s_y_zero  = (s_y == '0);
    assign s_x_pos   = ~s_x[IN_W-1] & ~s_x_zero;
    assign s_y_pos   = ~s_y[IN_W-1] & ~s_y_zero;
    // On equal magnitudes the north-south axis counts as the larger.
    assign s_swapped = (s_ax > s_ay);

    assign o_busy = i_full;
    assign o_push = i_start & ~i_full;

    always_comb begin
        o_item.tag.axis    = s_x_zero | s_y_zero;
        o_item.tag.x_pos   = s_x_pos;
        o_item.tag.y_pos   = s_y_pos;
        o_item.tag.swapped = s_swapped;
        if (s_x_zero) begin
            o_item.tag.axis_brg = s_y_pos ? BRG_NORTH : BRG_SOUTH;
        end else begin
            o_item.tag.axis_brg = s_x_pos ? BRG_EAST : BRG_WEST;
        end
        o_item.lo = s_swapped ? s_ay : s_ax;
        o_item.hi = s_swapped ? s_ax : s_ay;
    end

endmodule

`default_nettype wire

>>> hw/rtl/vba_queue.sv
// Short queue between the front end and the divider pipeline. The head is
// read into a register whenever the queue holds a beat.
// Depends on vba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vba_queue
    import vba_pkg::*;
#(
    parameter int Depth = Q_DEPTH
)(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_item     i_item,
    output logic      o_full,
    output logic      o_valid,
    output t_item     o_item
);

    localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CNT_W = $clog2(Depth + 1);

    t_item              r_mem [Depth];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               r_valid;
    t_item              r_item;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               s_pop;

    // The pipeline behind never stalls, so a held beat leaves every cycle.
    assign s_pop  = (r_count != '0);
    assign o_full = (r_count == CNT_W'(Depth));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(Depth - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (s_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(Depth - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_push && !s_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_push && s_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_valid  <= s_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
        if (s_pop) begin
            r_item <= r_mem[r_rd_ptr];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

>>> hw/rtl/vba_div.sv
// Pipelined restoring divider forming q = (lo << 14) / hi, one quotient bit
// per stage, with the octant tag carried alongside. Depends on vba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vba_div
    import vba_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  t_item      i_item,
    output logic       o_valid,
    output logic [Q_W-1:0] o_q,
    output t_tag       o_tag
);

    logic [REM_W-1:0] r_rem [DIV_STAGES];
    logic [IN_W-1:0]  r_hi  [DIV_STAGES];
    logic [Q_W-1:0]   r_q   [DIV_STAGES];
    t_tag             r_tag [DIV_STAGES];
    logic             r_vld [DIV_STAGES];

    logic [REM_W-1:0] n_rem   [DIV_STAGES];
    logic [Q_W-1:0]   n_q     [DIV_STAGES];
    logic [REM_W-1:0] s_trial [DIV_STAGES];
    logic [IN_W-1:0]  s_hi    [DIV_STAGES];
    logic [Q_W-1:0]   s_qin   [DIV_STAGES];
    logic             s_ge    [DIV_STAGES];

    // Since lo never exceeds hi, the top quotient bit is decided on lo itself
    // and every later stage shifts the remainder by one place.
    always_comb begin
        s_trial[0] = {1'b0, i_item.lo};
        s_hi[0]    = i_item.hi;
        s_qin[0]   = '0;
        for (int k = 1; k < DIV_STAGES; k++) begin
            s_trial[k] = {r_rem[k-1][REM_W-2:0], 1'b0};
            s_hi[k]    = r_hi[k-1];
            s_qin[k]   = r_q[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++) begin
            s_ge[k]  = (s_trial[k] >= {1'b0, s_hi[k]});
            n_rem[k] = s_ge[k] ? (s_trial[k] - {1'b0, s_hi[k]}) : s_trial[k];
            n_q[k]   = {s_qin[k][Q_W-2:0], s_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= i_valid;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_item.tag;
        for (int k = 1; k < DIV_STAGES; k++) begin
            r_tag[k] <= r_tag[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++) begin
            r_rem[k] <= n_rem[k];
            r_hi[k]  <= s_hi[k];
            r_q[k]   <= n_q[k];
        end
    end

    assign o_valid = r_vld[DIV_STAGES-1];
    assign o_q     = r_q[DIV_STAGES-1];
    assign o_tag   = r_tag[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> hw/rtl/vba_back.sv
// Back end of the bearing block: quadratic-corrected octant angle from the
// quotient in two multiply stages, then the fold into the full circle.
// Depends on vba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vba_back
    import vba_pkg::*;
(
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [Q_W-1:0] i_q,
    input  t_tag                i_tag,
    output logic                o_valid,
    output logic [BRG_W-1:0]    o_bearing
);

    localparam int CPROD_W = Q_W + 12;
    localparam int APROD_W = CORR_W + 1 + Q_W;

    logic [Q_W-1:0]     s_d;
    logic [CPROD_W-1:0] s_cprod;
    logic [CORR_W:0]    s_slope;
    logic [APROD_W-1:0] s_aprod;
    logic [BRG_W-1:0]   s_ang;
    logic [BRG_W-1:0]   n_brg;

    logic               r_a_vld;
    logic [CORR_W-1:0]  r_a_corr;
    logic [Q_W-1:0]     r_a_q;
    t_tag               r_a_tag;
    logic               r_b_vld;
    logic [BRG_W-1:0]   r_b_ang;
    t_tag               r_b_tag;
    logic               r_vld;
    logic [BRG_W-1:0]   r_brg;

    assign s_d     = (i_q > OCT_MID) ? (i_q - OCT_MID) : (OCT_MID - i_q);
    assign s_cprod = CPROD_W'(s_d) * CPROD_W'(OCT_CURVE);

    assign s_slope = OCT_BASE - {1'b0, r_a_corr};
    assign s_aprod = APROD_W'(s_slope) * APROD_W'(r_a_q);
    assign s_ang   = BRG_W'(s_aprod[APROD_W-1:FRAC_BITS]);

    // Axes take axis_brg; else fold by signs and larger magnitude; sums wrap.
    always_comb begin
        if (r_b_tag.axis) begin
            n_brg = r_b_tag.axis_brg;
        end else if (r_b_tag.x_pos) begin
            if (r_b_tag.y_pos) begin
                n_brg = r_b_tag.swapped ? (BRG_EAST - r_b_ang) : r_b_ang;
            end else begin
                n_brg = r_b_tag.swapped ? (BRG_EAST + r_b_ang) : (BRG_SOUTH - r_b_ang);
            end
        end else begin
            if (r_b_tag.y_pos) begin
                n_brg = r_b_tag.swapped ? (BRG_WEST + r_b_ang) : (BRG_NORTH - r_b_ang);
            end else begin
                n_brg = r_b_tag.swapped ? (BRG_WEST - r_b_ang) : (BRG_SOUTH + r_b_ang);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_vld   <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_corr <= CORR_W'(s_cprod[CPROD_W-1:FRAC_BITS]);
        r_a_q    <= i_q;
        r_a_tag  <= i_tag;
        r_b_ang  <= s_ang;
        r_b_tag  <= r_a_tag;
        r_brg    <= n_brg;
    end

    assign o_valid   = r_vld;
    assign o_bearing = r_brg;

endmodule

`default_nettype wire

>>> hw/rtl/vector_bearing_approx.sv
// Compass bearing of a signed vector as a 16-bit binary angle.
// Throughput: one vector per cycle; the queue drains every cycle, so busy stays low.
// Path: the accepting edge writes the queue, then come the head read, fifteen divider
// stages (one quotient bit each), two multiply stages and the fold register.
// Reset is synchronous and clears the queue and all valid bits; the receiver
// cannot stall, so every result is shown for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module vector_bearing_approx
    import vba_pkg::*;
#(
    parameter int QUEUE_DEPTH = Q_DEPTH
)(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic signed [IN_W-1:0] i_delta_x,
    input  wire logic signed [IN_W-1:0] i_delta_y,
    output logic                        o_valid,
    output logic [BRG_W-1:0]            o_bearing
);

    logic           s_full;
    logic           s_push;
    t_item          s_front_item;
    logic           s_q_valid;
    t_item          s_q_item;
    logic           s_div_valid;
    logic [Q_W-1:0] s_div_q;
    t_tag           s_div_tag;

    vba_front u_front (
        .i_start   (start),
        .i_full    (s_full),
        .i_delta_x (i_delta_x),
        .i_delta_y (i_delta_y),
        .o_busy    (busy),
        .o_push    (s_push),
        .o_item    (s_front_item)
    );

    vba_queue #(
        .Depth (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_item  (s_front_item),
        .o_full  (s_full),
        .o_valid (s_q_valid),
        .o_item  (s_q_item)
    );

    vba_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_q_valid),
        .i_item  (s_q_item),
        .o_valid (s_div_valid),
        .o_q     (s_div_q),
        .o_tag   (s_div_tag)
    );

    vba_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_div_valid),
        .i_q       (s_div_q),
        .i_tag     (s_div_tag),
        .o_valid   (o_valid),
        .o_bearing (o_bearing)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_vector_bearing_approx.sv
// Self-checking testbench for vector_bearing_approx: drives vectors through the start/busy
// handshake, predicts each bearing in step and checks every result beat in order.
// Depends on vba_pkg and the vector_bearing_approx RTL.
`timescale 1ns / 1ps

module tb_vector_bearing_approx;
    import vba_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 9;
    localparam int LATENCY      = 19;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int MAX_REPORTED = 10;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic signed [IN_W-1:0] i_delta_x;
    logic signed [IN_W-1:0] i_delta_y;
    logic                   o_valid;
    logic [BRG_W-1:0]       o_bearing;

    logic [BRG_W-1:0] pending_bearings[$];
    int               mismatch_count;
    bit               idling_on;

    vector_bearing_approx u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_delta_x (i_delta_x),
        .i_delta_y (i_delta_y),
        .o_valid   (o_valid),
        .o_bearing (o_bearing)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Generous bound: well over ten times the slowest legal run.
    initial begin
        #(20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [BRG_W-1:0] predict_bearing(input logic signed [IN_W-1:0] dx,
                                                        input logic signed [IN_W-1:0] dy);
        int               x, y, ax, ay, lo, hi, q, dev, corr;
        logic [BRG_W-1:0] ang;
        logic             swapped;
        x = dx;
        y = dy;
        if (x == 0)
            return (y > 0) ? BRG_NORTH : BRG_SOUTH;
        if (y == 0)
            return (x > 0) ? BRG_EAST : BRG_WEST;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        // A tie leaves the north-south axis as the larger magnitude.
        swapped = ax > ay;
        lo = swapped ? ay : ax;
        hi = swapped ? ax : ay;
        q = (lo << FRAC_BITS) / hi;
        dev = (q > int'(OCT_MID)) ? q - int'(OCT_MID) : int'(OCT_MID) - q;
        corr = (dev * int'(OCT_CURVE)) >> FRAC_BITS;
        ang = BRG_W'(((int'(OCT_BASE) - corr) * q) >> FRAC_BITS);
        if (x > 0) begin
            if (y > 0)
                return swapped ? BRG_EAST - ang : ang;
            else
                return swapped ? BRG_EAST + ang : BRG_SOUTH - ang;
        end else begin
            if (y > 0)
                return swapped ? BRG_WEST + ang : BRG_NORTH - ang;
            else
                return swapped ? BRG_WEST - ang : BRG_SOUTH + ang;
        end
    endfunction

    // Checks each result beat against the oldest outstanding bearing.
    always @(posedge i_clk) begin
        logic [BRG_W-1:0] want;
        if (i_rst_n === 1'b1) begin
            if ($isunknown(o_valid)) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                    $display("[%0t] o_valid is unknown", $realtime);
            end else if (o_valid) begin
                if (pending_bearings.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("[%0t] unexpected result beat, bearing %h",
                                 $realtime, o_bearing);
                end else begin
                    want = pending_bearings.pop_front();
                    if (o_bearing !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTED)
                            $display("[%0t] bearing mismatch: expected %h, actual %h",
                                     $realtime, want, o_bearing);
                    end
                end
            end
        end
    end

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // Presents one vector and holds it until the block takes the beat.
    task automatic send_vector(input logic signed [IN_W-1:0] dx,
                               input logic signed [IN_W-1:0] dy);
        if (idling_on && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 19));
        @(negedge i_clk);
        start     <= 1'b1;
        i_delta_x <= dx;
        i_delta_y <= dy;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        pending_bearings.push_back(predict_bearing(dx, dy));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_bearings.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic signed [IN_W-1:0] random_component();
        return IN_W'($urandom_range(0, 65534) - 32767);
    endfunction

    function automatic logic signed [IN_W-1:0] random_small();
        return IN_W'(int'($urandom_range(0, 16)) - 8);
    endfunction

    task automatic test_axes();
        send_vector(16'sd0, 16'sd0);
        send_vector(16'sd0, 16'sd1);
        send_vector(16'sd0, 16'sd32767);
        send_vector(16'sd0, -16'sd1);
        send_vector(16'sd0, -16'sd32767);
        send_vector(16'sd1, 16'sd0);
        send_vector(16'sd32767, 16'sd0);
        send_vector(-16'sd1, 16'sd0);
        send_vector(-16'sd32767, 16'sd0);
    endtask

    // Equal magnitudes in every quadrant at the top of the range, and in two at the bottom.
    task automatic test_diagonals();
        send_vector(16'sd32767, 16'sd32767);
        send_vector(16'sd32767, -16'sd32767);
        send_vector(-16'sd32767, 16'sd32767);
        send_vector(-16'sd32767, -16'sd32767);
        send_vector(16'sd1, -16'sd1);
        send_vector(-16'sd1, 16'sd1);
    endtask

    // The steepest and shallowest vectors, one per octant.
    task automatic test_octants();
        send_vector(16'sd1, 16'sd32767);
        send_vector(16'sd32767, 16'sd1);
        send_vector(16'sd32767, -16'sd1);
        send_vector(16'sd1, -16'sd32767);
        send_vector(-16'sd1, -16'sd32767);
        send_vector(-16'sd32767, -16'sd1);
        send_vector(-16'sd32767, 16'sd1);
        send_vector(-16'sd1, 16'sd32767);
    endtask

    task automatic test_random_vectors(input int count);
        logic signed [IN_W-1:0] dx, dy;
        int                     mag, shape;
        for (int n = 0; n < count; n++) begin
            shape = $urandom_range(0, 9);
            dx = random_component();
            dy = random_component();
            case (shape)
                6: begin
                    dx = random_small();
                    dy = random_small();
                end
                7: begin
                    // Near-equal magnitudes sit on the octant boundary.
                    mag = (dx < 0) ? -int'(dx) : int'(dx);
                    mag = mag + int'($urandom_range(0, 4)) - 2;
                    if (mag > 32767)
                        mag = 32767;
                    if (mag < 0)
                        mag = 0;
                    dy = $urandom_range(0, 1) ? IN_W'(mag) : IN_W'(-mag);
                end
                8: begin
                    if ($urandom_range(0, 1))
                        dx = 16'sd0;
                    else
                        dy = 16'sd0;
                end
                9: begin
                    dx = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32767;
                    dy = $urandom_range(0, 1) ? random_small() : -16'sd32767;
                end
                default: ;
            endcase
            send_vector(dx, dy);
        end
    endtask

    // The sender stops until the block has emptied, then resumes.
    task automatic test_drain_pause();
        test_random_vectors(20);
        wait_for_results();
        test_random_vectors(20);
        wait_for_results();
    endtask

    task automatic test_back_to_back(input int count);
        idling_on = 1'b0;
        test_random_vectors(count);
    endtask

    initial begin
        int waited;
        mismatch_count = 0;
        idling_on      = 1'b1;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_delta_x      = '0;
        i_delta_y      = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_axes();
        test_diagonals();
        test_octants();
        test_random_vectors(1300);
        test_drain_pause();
        test_back_to_back(400);

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (pending_bearings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_bearings.size() != 0) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            // Extra cycles catch any stray beat after the last expected one.
            repeat (LATENCY + 6) @(posedge i_clk);
            if (pending_bearings.size() != 0)
                mismatch_count++;
            if (mismatch_count == 0)
                $display("Testbench completed without errors");
            else
                $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

>>> filelist.f
hw/rtl/vba_pkg.sv
hw/rtl/vba_front.sv
hw/rtl/vba_queue.sv
hw/rtl/vba_div.sv
hw/rtl/vba_back.sv
hw/rtl/vector_bearing_approx.sv
tb/sv/tb_vector_bearing_approx.sv
